[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files.
// Depends on nothing; the user supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form of the above.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

[rtl/core/fbds_pkg.sv]
// Constants and the Q12 fraction helper for the fractional baud divisor solver.
// No dependencies.
`default_nettype none
package fbds_pkg;

  localparam int CLK_W  = 26;
  localparam int BAUD_W = 24;
  localparam int DL_W   = 16;
  localparam int FT_W   = 4;
  localparam int DIV_W  = 18;   // clamped baud fits here
  localparam int Q_W    = 23;   // (clock * 64) / baud with baud >= 1000
  localparam int D_W    = Q_W + 2;
  localparam int FRAC_W = 12;

  localparam int MAX_FRACTION_TERM = 15;

  localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(12000000);
  localparam logic [BAUD_W-1:0] BAUD_MIN    = BAUD_W'(1000);
  localparam logic [BAUD_W-1:0] BAUD_MAX    = BAUD_W'(172800);
  localparam logic [DIV_W-1:0]  BAUD_DEF    = DIV_W'(9600);

  localparam logic [FRAC_W-1:0] FRAC_LOW  = 12'h00f;
  localparam logic [FRAC_W-1:0] FRAC_HIGH = 12'hff0;
  localparam logic [D_W-1:0]    D_FAIL    = D_W'(12'hff0);

  // round(a * 4096 / m), half up, by restoring long division
  function automatic int unsigned frac_q12(int unsigned a, int unsigned m);
    int unsigned num;
    int unsigned rem;
    int unsigned q;
    num = a << 13;
    rem = 0;
    q   = 0;
    for (int i = 16; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 1);
      q   = q << 1;
      if (rem >= m) begin
        rem = rem - m;
        q   = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

endpackage
`default_nettype wire

[rtl/core/fractional_baud_divisor_solver.sv]
// Fractional baud divisor solver: pipelined divider, divisor split, error tree.
// Depends on fbds_pkg.
//
//  channel | ports                                                      | handshake
//  --------+------------------------------------------------------------+-------------------
//  in      | in_baud_rate                                               | in_valid/in_stall
//  out     | out_integer_divisor, out_div_add_value, out_mul_value, out_failed | out_valid/out_stall
//  cfg     | cfg_wr_data                                                | cfg_wr_en
//
// One request per cycle while the output is not stalled; a stall backs up the pipe.
// The pipe is the bit-per-stage divider, the divisor split and the registered min tree.
// Stages with no data take a new item even when the output is stalled.
// Synchronous active-low reset clears valids and sets the clock to 12 MHz.
`default_nettype none
module fractional_baud_divisor_solver #(
  parameter int MAX_FRACTION_TERM = fbds_pkg::MAX_FRACTION_TERM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fbds_pkg::CLK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fbds_pkg::BAUD_W-1:0]   in_baud_rate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbds_pkg::DL_W-1:0]     out_integer_divisor,
  output logic [fbds_pkg::FT_W-1:0]     out_div_add_value,
  output logic [fbds_pkg::FT_W-1:0]     out_mul_value,
  output logic                          out_failed
);

  localparam int QW    = fbds_pkg::Q_W;
  localparam int DVW   = fbds_pkg::DIV_W;
  localparam int DW    = fbds_pkg::D_W;
  localparam int FW    = fbds_pkg::FRAC_W;
  localparam int FTW   = fbds_pkg::FT_W;
  localparam int DLW   = fbds_pkg::DL_W;
  localparam int NPAIR = MAX_FRACTION_TERM * (MAX_FRACTION_TERM - 1) / 2;
  localparam int LV    = (NPAIR > 1) ? $clog2(NPAIR) : 0;
  localparam int NP2   = 1 << LV;
  localparam int EW    = FW + 1;
  localparam int KW    = $clog2(DW - FW);
  localparam int ST_A  = QW + 1;
  localparam int ST_L  = QW + 2;
  localparam int ST_O  = ST_L + LV + 1;
  localparam int NST   = ST_O + 1;

  logic [fbds_pkg::CLK_W-1:0] clk_hz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= fbds_pkg::CLOCK_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // valid pipe; each stage moves when it is empty or the next one moves
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  // stage 0: clamp baud, split clock*64 into initial remainder and low bits
  logic [DVW-1:0] baud_c;
  logic [DVW-1:0] dv_r  [QW];
  logic [DVW-1:0] rem_r [QW];
  logic [QW-1:0]  nl_r  [QW];
  logic [QW-1:0]  q_r   [QW+1];

  always_comb begin
    if (in_baud_rate < fbds_pkg::BAUD_MIN || in_baud_rate > fbds_pkg::BAUD_MAX) begin
      baud_c = fbds_pkg::BAUD_DEF;
    end else begin
      baud_c = in_baud_rate[DVW-1:0];
    end
  end

  // top quotient bits are zero, so the top clock bits are the first remainder
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dv_r[0]  <= baud_c;
      rem_r[0] <= DVW'(clk_hz_r[fbds_pkg::CLK_W-1:QW-6]);
      nl_r[0]  <= {clk_hz_r[QW-7:0], 6'b0};
      q_r[0]   <= '0;
    end
  end

  // stages 1..QW: one quotient bit each
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [DVW:0] trial;
    logic         ge;
    assign trial = {rem_r[j-1], nl_r[j-1][QW-1]};
    assign ge    = trial >= {1'b0, dv_r[j-1]};
    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        q_r[j] <= {q_r[j-1][QW-2:0], ge};
      end
    end
    if (j < QW) begin : g_carry
      logic [DVW:0] diff;
      assign diff = trial - {1'b0, dv_r[j-1]};
      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          rem_r[j] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
          nl_r[j]  <= {nl_r[j-1][QW-2:0], 1'b0};
          dv_r[j]  <= dv_r[j-1];
        end
      end
    end
  end

  // stage A: D, failure, near-whole test, power-of-two split
  logic [DW-1:0]  d_c;
  logic [FW-1:0]  frac_c;
  logic [KW-1:0]  k_c;
  logic [DW-FW:0] whole_c;
  logic           near_c;
  logic [DLW-1:0] a_dl_r;
  logic           a_fail_r;
  logic           a_near_r;
  logic [FW-1:0]  a_tgt_r;

  always_comb begin
    d_c     = {q_r[QW], 2'b00};
    frac_c  = d_c[FW-1:0];
    near_c  = frac_c < fbds_pkg::FRAC_LOW || frac_c > fbds_pkg::FRAC_HIGH;
    whole_c = {1'b0, d_c[DW-1:FW]} + (DW-FW+1)'(frac_c > fbds_pkg::FRAC_HIGH);
    k_c     = '0;
    for (int i = 0; i <= DW - FW - 1; i++) begin
      if (d_c[FW+i]) k_c = KW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_A]) begin
      a_fail_r <= d_c <= fbds_pkg::D_FAIL;
      a_near_r <= near_c;
      a_dl_r   <= near_c ? DLW'(whole_c) : DLW'((DLW+1)'(1) << k_c);
      a_tgt_r  <= FW'(d_c >> k_c);
    end
  end

  // leaves: error of every candidate against the target
  logic [EW-1:0]  lf_e [NP2];
  logic [FTW-1:0] lf_a [NP2];
  logic [FTW-1:0] lf_m [NP2];

  for (genvar a = 1; a < MAX_FRACTION_TERM; a++) begin : g_add
    for (genvar m = a + 1; m <= MAX_FRACTION_TERM; m++) begin : g_mul
      localparam int IDX = (a - 1) * MAX_FRACTION_TERM - (a - 1) * a / 2 + (m - a - 1);
      localparam logic [FW-1:0] QC = FW'(fbds_pkg::frac_q12(a, m));
      assign lf_e[IDX] = (QC >= a_tgt_r) ? EW'(QC - a_tgt_r) : EW'(a_tgt_r - QC);
      assign lf_a[IDX] = FTW'(a);
      assign lf_m[IDX] = FTW'(m);
    end
  end

  for (genvar k = NPAIR; k < NP2; k++) begin : g_pad
    assign lf_e[k] = '1;
    assign lf_a[k] = '0;
    assign lf_m[k] = '0;
  end

  logic [EW-1:0]  le_r [LV+1][NP2];
  logic [FTW-1:0] la_r [LV+1][NP2];
  logic [FTW-1:0] lm_r [LV+1][NP2];
  logic [DLW-1:0] sd_dl_r   [LV+1];
  logic           sd_fail_r [LV+1];
  logic           sd_near_r [LV+1];

  always_ff @(posedge clk) begin
    if (rdy[ST_L]) begin
      for (int k = 0; k < NP2; k++) begin
        le_r[0][k] <= lf_e[k];
        la_r[0][k] <= lf_a[k];
        lm_r[0][k] <= lf_m[k];
      end
      sd_dl_r[0]   <= a_dl_r;
      sd_fail_r[0] <= a_fail_r;
      sd_near_r[0] <= a_near_r;
    end
  end

  // min tree, one registered level per stage; the earlier pair wins ties
  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      if (rdy[ST_L+l]) begin
        sd_dl_r[l]   <= sd_dl_r[l-1];
        sd_fail_r[l] <= sd_fail_r[l-1];
        sd_near_r[l] <= sd_near_r[l-1];
      end
    end
    for (genvar k = 0; k < NP2; k++) begin : g_node
      if (k < (NP2 >> l)) begin : g_cmp
        logic pick;
        assign pick = le_r[l-1][2*k+1] < le_r[l-1][2*k];
        always_ff @(posedge clk) begin
          if (rdy[ST_L+l]) begin
            le_r[l][k] <= pick ? le_r[l-1][2*k+1] : le_r[l-1][2*k];
            la_r[l][k] <= pick ? la_r[l-1][2*k+1] : la_r[l-1][2*k];
            lm_r[l][k] <= pick ? lm_r[l-1][2*k+1] : lm_r[l-1][2*k];
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          le_r[l][k] <= '0;
          la_r[l][k] <= '0;
          lm_r[l][k] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[ST_O]) begin
      if (sd_fail_r[LV]) begin
        out_integer_divisor <= '0;
        out_div_add_value   <= '0;
        out_mul_value       <= '0;
        out_failed          <= 1'b1;
      end else if (sd_near_r[LV]) begin
        out_integer_divisor <= sd_dl_r[LV];
        out_div_add_value   <= '0;
        out_mul_value       <= FTW'(1);
        out_failed          <= 1'b0;
      end else begin
        out_integer_divisor <= sd_dl_r[LV];
        out_div_add_value   <= la_r[LV][0];
        out_mul_value       <= lm_r[LV][0];
        out_failed          <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/fbds_checker.sv]
// Port-level checker for the fractional baud divisor solver, with its bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fbds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_integer_divisor,
  input logic [3:0]  out_div_add_value,
  input logic [3:0]  out_mul_value,
  input logic        out_failed
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_integer_divisor) && $stable(out_mul_value), "stalled result changed")
  `ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_failed, out_integer_divisor == 16'd0 && out_div_add_value == 4'd0 && out_mul_value == 4'd0, "failed result not zero")
  `ASSERT_IMP(a_ok_div, clk, rst_n, out_valid && !out_failed, out_mul_value != 4'd0 && out_integer_divisor != 16'd0, "success with zero divisor")
  `ASSERT_IMP(a_frac_order, clk, rst_n, out_valid && !out_failed, out_div_add_value < out_mul_value, "add value not below multiplier")

endmodule

bind fractional_baud_divisor_solver fbds_checker u_fbds_checker (.*);
`default_nettype wire

[dv/testbench.sv]
// Self-checking bench for fractional_baud_divisor_solver: directed table, then random requests.
// Depends on fbds_pkg and the solver RTL; results predicted in-bench and compared in order.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbds_pkg::*;

  typedef struct packed {
    logic [DL_W-1:0] dl;
    logic [FT_W-1:0] add;
    logic [FT_W-1:0] mul;
    logic            fail;
  } divisor_t;

  typedef struct {
    logic [CLK_W-1:0]  clock;    // 0 = keep the current clock
    logic [BAUD_W-1:0] baud;
    bit                known;
    divisor_t          want;
  } row_t;

  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG     = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CLK_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic [BAUD_W-1:0] in_baud_rate = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, out_failed;
  logic [DL_W-1:0] out_integer_divisor;
  logic [FT_W-1:0] out_div_add_value, out_mul_value;

  logic [CLK_W-1:0] clock_hz = CLOCK_RESET;
  divisor_t pending_divisors[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_hold = 1'b0;

  always #2 clk = ~clk;

  fractional_baud_divisor_solver DUT (.*);

  function automatic divisor_t solve_divisor(logic [CLK_W-1:0] clk_hz, logic [BAUD_W-1:0] b);
    longint unsigned baud, d, frac, p2, tgt, q, err, best;
    divisor_t r;
    baud = b;
    r = '0;
    if (baud < 1000 || baud > 172800) baud = 9600;
    d = ((longint'(clk_hz) << 6) / baud) << 2;
    if (d <= 'hff0) begin
      r.fail = 1'b1;
      return r;
    end
    frac = d & 'hfff;
    if (frac < 'hf || frac > 'hff0) begin
      r.dl = DL_W'((d >> 12) + (frac > 'hff0 ? 1 : 0));
      r.mul = FT_W'(1);
      return r;
    end
    p2 = 'h1000;
    while ((d >> 1) >= p2) p2 = p2 << 1;
    tgt = d / (p2 >> 12) - 'h1000;
    best = '1;
    for (int a = 1; a <= MAX_FRACTION_TERM; a++)
      for (int m = a + 1; m <= MAX_FRACTION_TERM; m++) begin
        q = ((longint'(a) << 13) / m + 1) >> 1;
        err = q >= tgt ? q - tgt : tgt - q;
        if (err < best) begin
          best = err;
          r.add = FT_W'(a);
          r.mul = FT_W'(m);
        end
      end
    r.dl = DL_W'(p2 >> 12);
    return r;
  endfunction

  task automatic set_clock(logic [CLK_W-1:0] v);
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clock_hz = v;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // Sends one request; optionally checks the prediction against a typed value.
  task automatic send_request(logic [BAUD_W-1:0] b, bit known, divisor_t want, bit gaps);
    divisor_t p;
    int gap;
    p = solve_divisor(clock_hz, b);
    if (known && p !== want) begin
      $display("%0t table/predictor disagree baud %0d: expected %h actual %h", $time, b, want, p);
      errors++;
    end
    gap = gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_baud_rate <= b;
    do @(posedge clk); while (in_stall);
    pending_divisors.push_back(known ? want : p);
  endtask

  // out side: random stall, check each transfer
  always @(posedge clk) begin
    divisor_t got, exp_d;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_integer_divisor, out_div_add_value, out_mul_value, out_failed};
        if (pending_divisors.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual %h", $time, got);
          errors++;
        end else begin
          exp_d = pending_divisors.pop_front();
          if (got.dl !== exp_d.dl) begin
            $display("%0t integer_divisor: expected %0d actual %0d", $time, exp_d.dl, got.dl);
            errors++;
          end
          if (got.add !== exp_d.add) begin
            $display("%0t div_add_value: expected %0d actual %0d", $time, exp_d.add, got.add);
            errors++;
          end
          if (got.mul !== exp_d.mul) begin
            $display("%0t mul_value: expected %0d actual %0d", $time, exp_d.mul, got.mul);
            errors++;
          end
          if (got.fail !== exp_d.fail) begin
            $display("%0t failed: expected %0d actual %0d", $time, exp_d.fail, got.fail);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 99) < 3) stall_hold <= ~stall_hold;
      out_stall <= stall_hold ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 4) == 0);
      idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  row_t table_rows[] = '{
    '{0, 24'd9600,   1, '{16'd64, 4'd2, 4'd9, 1'b0}},
    '{0, 24'd0,      1, '{16'd64, 4'd2, 4'd9, 1'b0}},
    '{0, 24'hffffff, 1, '{16'd64, 4'd2, 4'd9, 1'b0}},
    '{0, 24'd999,    0, '0},
    '{0, 24'd1000,   0, '0},
    '{0, 24'd172800, 0, '0},
    '{0, 24'd172801, 1, '{16'd64, 4'd2, 4'd9, 1'b0}},
    '{0, 24'd115200, 0, '0},
    '{0, 24'd46875,  1, '{16'd16, 4'd0, 4'd1, 1'b0}},
    '{0, 24'd57600,  0, '0},
    '{1, 24'd9600,   1, '{16'd0, 4'd0, 4'd0, 1'b1}},
    '{1, 24'd1000,   1, '{16'd0, 4'd0, 4'd0, 1'b1}},
    '{26'd16000, 24'd1000, 1, '{16'd1, 4'd0, 4'd1, 1'b0}},
    '{0, 24'd1001,   0, '0},
    '{26'h3ffffff, 24'd1000, 0, '0},
    '{0, 24'd172800, 0, '0},
    '{0, 24'h555555, 0, '0},
    '{0, 24'h02aaaa, 0, '0},
    '{26'd1843200, 24'd115200, 1, '{16'd1, 4'd0, 4'd1, 1'b0}},
    '{0, 24'd38400,  0, '0}
  };

  initial begin
    logic [BAUD_W-1:0] b;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].clock != 0) begin
        in_valid <= 1'b0;
        set_clock(table_rows[i].clock);
      end
      send_request(table_rows[i].baud, table_rows[i].known, table_rows[i].want, 1'b0);
    end
    for (int n = 0; n < 800; n++) begin
      if (n % 100 == 0) begin
        in_valid <= 1'b0;
        case ($urandom_range(0, 4))
          0: set_clock(CLK_W'(1));
          1: set_clock('1);
          2: set_clock(CLK_W'($urandom_range(1, 67108863)));
          3: set_clock(CLK_W'($urandom_range(1000000, 60000000)));
          default: set_clock(CLK_W'($urandom_range(16000, 3000000)));
        endcase
      end
      r = $urandom_range(0, 9);
      if (r < 7) b = BAUD_W'($urandom_range(1000, 172800));
      else if (r < 9) b = BAUD_W'($urandom);
      else b = BAUD_W'($urandom_range(990, 1010));
      send_request(b, 1'b0, '0, 1'b1);
    end
    in_valid <= 1'b0;
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/fbds_pkg.sv
rtl/core/fractional_baud_divisor_solver.sv
rtl/core/fbds_checker.sv
dv/testbench.sv
